FILE: src/sfrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_pkg
// Shared constants, types and helpers for the frame resync parser.
// ----------------------------------------------------------------------------
package sfrp_pkg;

  localparam int FRAME_BYTES      = 98;
  localparam int ROWS_PER_FRAME   = 10;
  localparam int CHANNELS_PER_ROW = 8;
  localparam int SAMPLE_BASE      = 16;
  localparam int BATTERY_AT       = 96;
  localparam int TIME_AT          = 3;
  localparam int KIND_AT          = 2;

  localparam int ADDR_W  = 7;
  localparam int ROW_W   = 4;
  localparam int CH_W    = 3;
  localparam int ODATA_W = 184;

  // APB register indexes
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_FRAME_KIND    = 2'd2;
  localparam logic [1:0] REG_TAIL_VALUE    = 2'd3;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_DROP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_KIND_RD,
    S_KIND_CMP,
    S_TAIL_CMP,
    S_TM_RD,
    S_TM_USE,
    S_BAT_RD,
    S_BAT_USE,
    S_ROW_RD,
    S_ROW_USE,
    S_ROW_LD,
    S_STAT,
    S_OUT
  } state_t;

  // ring index: (a + b) mod FRAME_BYTES, both operands below FRAME_BYTES
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(FRAME_BYTES)) s = s - (ADDR_W+1)'(FRAME_BYTES);
    return s[ADDR_W-1:0];
  endfunction

endpackage

FILE: src/sensor_frame_resync_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_resync_parser_unit
// Byte-stream frame parser that resyncs on a two-byte header.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words arrive on s_*: s_tdata carries the byte, s_tuser the command
//    (feed or drop pending bytes). s_tready is high only while idle.
//  - Each input word yields one status word, or one word per sample row when a
//    frame completes (m_tuser high on row words, m_tlast on the final word).
//  - Header, type and tail bytes are set over the APB port; the user must
//    write them only while idle, as the block itself does not enforce it.
//  - Bytes live in a ring memory addressed from a head pointer; one read port
//    is shared by the header search, the frame check and the decode.
//  - Header search reads and compares each held byte in turn; a type or tail
//    mismatch drops one byte, then the search restarts from the front. A
//    status word is then loaded.
//  - Frame decode: the time and battery bytes are read, then each row reads its
//    channel bytes, loads the row word and waits for its handshake.
//  - The next input word can be taken from the cycle after the last result handshake.
// Reset clears fill level, head, counters and the config registers to their
// defaults. The memory is not cleared: only bytes below the fill level are read.
// When m_tready is low the result word holds in the output register and the
// sequencer waits.
// ----------------------------------------------------------------------------
module sensor_frame_resync_parser_unit (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_tuser,   // [0] command
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] row_number, [67:4] row_samples, [99:68] frame_time_ms,
  // [107:100] battery_level, [114:108] pending_count, [146:115] error_total,
  // [178:147] discard_total, rest zero
  output logic [sfrp_pkg::ODATA_W-1:0] m_tdata,
  output logic [0:0]   m_tuser,   // [0] frame_row_valid
  output logic         m_tlast,   // last_row
  // APB config
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = sfrp_pkg::ADDR_W;

  sfrp_pkg::state_t state, state_next;

  logic [AW-1:0] head, fill, idx;
  logic          prevm;
  logic [31:0]   err_cnt, disc_cnt;
  logic [31:0]   time_acc;
  logic [7:0]    batt;
  logic [63:0]   samples;
  logic [sfrp_pkg::ROW_W-1:0] row;
  logic [sfrp_pkg::CH_W-1:0]  ch;
  logic [7:0]    hdr_first, hdr_second, kind, tail;

  logic          in_acc, out_acc;
  logic [AW-1:0] rd_idx, rd_addr, wr_addr, at;
  logic [7:0]    rd_data, row_pos;
  logic          wr_en, row_in_frame, last_row_now;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign s_tready = (state == sfrp_pkg::S_IDLE);
  assign at = idx - AW'(1);

  // sample byte position for the current row and channel
  assign row_pos = 8'(sfrp_pkg::SAMPLE_BASE)
                 + 8'(row) * 8'(sfrp_pkg::CHANNELS_PER_ROW) + 8'(ch);
  assign row_in_frame = row_pos < 8'(sfrp_pkg::FRAME_BYTES);
  assign last_row_now = (row == sfrp_pkg::ROW_W'(sfrp_pkg::ROWS_PER_FRAME - 1));

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      sfrp_pkg::REG_HEADER_FIRST:  prdata = {24'd0, hdr_first};
      sfrp_pkg::REG_HEADER_SECOND: prdata = {24'd0, hdr_second};
      sfrp_pkg::REG_FRAME_KIND:    prdata = {24'd0, kind};
      sfrp_pkg::REG_TAIL_VALUE:    prdata = {24'd0, tail};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= 8'd170;
      hdr_second <= 8'd85;
      kind       <= 8'd1;
      tail       <= 8'd85;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        sfrp_pkg::REG_HEADER_FIRST:  hdr_first  <= pwdata[7:0];
        sfrp_pkg::REG_HEADER_SECOND: hdr_second <= pwdata[7:0];
        sfrp_pkg::REG_FRAME_KIND:    kind       <= pwdata[7:0];
        sfrp_pkg::REG_TAIL_VALUE:    tail       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- memory ----------------
  // full buffer: new byte lands on the oldest slot, head moves past it
  assign wr_en   = in_acc && (s_tuser[0] == sfrp_pkg::CMD_FEED);
  assign wr_addr = (fill == AW'(sfrp_pkg::FRAME_BYTES)) ? head
                                                         : sfrp_pkg::ring_add(head, fill);

  always_comb begin
    case (state)
      sfrp_pkg::S_KIND_RD:  rd_idx = AW'(sfrp_pkg::KIND_AT);
      sfrp_pkg::S_KIND_CMP: rd_idx = AW'(sfrp_pkg::FRAME_BYTES - 1);
      sfrp_pkg::S_BAT_RD:   rd_idx = AW'(sfrp_pkg::BATTERY_AT);
      sfrp_pkg::S_ROW_RD:   rd_idx = row_in_frame ? row_pos[AW-1:0] : '0;
      default:              rd_idx = idx;
    endcase
  end
  assign rd_addr = sfrp_pkg::ring_add(head, rd_idx);

  sfrp_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= sfrp_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      sfrp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = (s_tuser[0] == sfrp_pkg::CMD_DROP) ? sfrp_pkg::S_STAT
                                                          : sfrp_pkg::S_SCAN_RD;
        end
      end
      sfrp_pkg::S_SCAN_RD: begin
        state_next = (idx == fill) ? sfrp_pkg::S_STAT : sfrp_pkg::S_SCAN_CMP;
      end
      sfrp_pkg::S_SCAN_CMP: begin
        if (prevm && rd_data == hdr_second) begin
          state_next = ((fill - at) < AW'(sfrp_pkg::FRAME_BYTES)) ? sfrp_pkg::S_STAT
                                                                  : sfrp_pkg::S_KIND_RD;
        end else begin
          state_next = sfrp_pkg::S_SCAN_RD;
        end
      end
      sfrp_pkg::S_KIND_RD:  state_next = sfrp_pkg::S_KIND_CMP;
      sfrp_pkg::S_KIND_CMP: begin
        state_next = (rd_data != kind) ? sfrp_pkg::S_SCAN_RD : sfrp_pkg::S_TAIL_CMP;
      end
      sfrp_pkg::S_TAIL_CMP: begin
        state_next = (rd_data != tail) ? sfrp_pkg::S_SCAN_RD : sfrp_pkg::S_TM_RD;
      end
      sfrp_pkg::S_TM_RD:  state_next = sfrp_pkg::S_TM_USE;
      sfrp_pkg::S_TM_USE: begin
        state_next = (idx == AW'(sfrp_pkg::TIME_AT + 3)) ? sfrp_pkg::S_BAT_RD
                                                         : sfrp_pkg::S_TM_RD;
      end
      sfrp_pkg::S_BAT_RD:  state_next = sfrp_pkg::S_BAT_USE;
      sfrp_pkg::S_BAT_USE: state_next = sfrp_pkg::S_ROW_RD;
      sfrp_pkg::S_ROW_RD:  state_next = sfrp_pkg::S_ROW_USE;
      sfrp_pkg::S_ROW_USE: begin
        state_next = (ch == sfrp_pkg::CH_W'(sfrp_pkg::CHANNELS_PER_ROW - 1))
                   ? sfrp_pkg::S_ROW_LD : sfrp_pkg::S_ROW_RD;
      end
      sfrp_pkg::S_ROW_LD: state_next = sfrp_pkg::S_OUT;
      sfrp_pkg::S_STAT:   state_next = sfrp_pkg::S_OUT;
      sfrp_pkg::S_OUT: begin
        if (out_acc) begin
          state_next = (m_tuser[0] && !last_row_now) ? sfrp_pkg::S_ROW_RD
                                                     : sfrp_pkg::S_IDLE;
        end
      end
      default: state_next = sfrp_pkg::S_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill     <= '0;
      err_cnt  <= '0;
      disc_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        sfrp_pkg::S_IDLE: begin
          if (in_acc) begin
            idx   <= '0;
            prevm <= 1'b0;
            if (s_tuser[0] == sfrp_pkg::CMD_DROP) begin
              fill <= '0;
            end else if (fill == AW'(sfrp_pkg::FRAME_BYTES)) begin
              err_cnt  <= err_cnt + 32'd1;
              disc_cnt <= disc_cnt + 32'd1;
              head     <= sfrp_pkg::ring_add(head, AW'(1));
            end else begin
              fill <= fill + AW'(1);
            end
          end
        end
        sfrp_pkg::S_SCAN_RD: begin
          if (idx == fill) begin
            // no header: keep a trailing first header byte, else empty
            if (prevm) begin
              disc_cnt <= disc_cnt + 32'(fill - AW'(1));
              head     <= sfrp_pkg::ring_add(head, fill - AW'(1));
              fill     <= AW'(1);
            end else begin
              disc_cnt <= disc_cnt + 32'(fill);
              fill     <= '0;
            end
          end
        end
        sfrp_pkg::S_SCAN_CMP: begin
          if (prevm && rd_data == hdr_second) begin
            disc_cnt <= disc_cnt + 32'(at);
            head     <= sfrp_pkg::ring_add(head, at);
            fill     <= fill - at;
          end else begin
            prevm <= (rd_data == hdr_first);
            idx   <= idx + AW'(1);
          end
        end
        sfrp_pkg::S_KIND_CMP, sfrp_pkg::S_TAIL_CMP: begin
          if ((state == sfrp_pkg::S_KIND_CMP && rd_data != kind) ||
              (state == sfrp_pkg::S_TAIL_CMP && rd_data != tail)) begin
            // bad frame: drop one byte and search again
            err_cnt  <= err_cnt + 32'd1;
            disc_cnt <= disc_cnt + 32'd1;
            head     <= sfrp_pkg::ring_add(head, AW'(1));
            fill     <= fill - AW'(1);
            idx      <= '0;
            prevm    <= 1'b0;
          end else if (state == sfrp_pkg::S_TAIL_CMP) begin
            fill     <= '0;
            idx      <= AW'(sfrp_pkg::TIME_AT);
            time_acc <= '0;
          end
        end
        sfrp_pkg::S_TM_USE: begin
          time_acc <= {time_acc[23:0], rd_data};
          idx      <= idx + AW'(1);
        end
        sfrp_pkg::S_BAT_USE: begin
          batt    <= rd_data;
          row     <= '0;
          ch      <= '0;
          samples <= '0;
        end
        sfrp_pkg::S_ROW_USE: begin
          samples[8*ch +: 8] <= row_in_frame ? rd_data : 8'd0;
          ch <= ch + sfrp_pkg::CH_W'(1);
        end
        sfrp_pkg::S_ROW_LD: begin
          m_tvalid <= 1'b1;
          m_tuser  <= 1'b1;
          m_tlast  <= last_row_now;
          m_tdata  <= {5'd0, disc_cnt, err_cnt, 7'd0, batt, time_acc, samples, row};
        end
        sfrp_pkg::S_STAT: begin
          m_tvalid <= 1'b1;
          m_tuser  <= 1'b0;
          m_tlast  <= 1'b1;
          m_tdata  <= {5'd0, disc_cnt, err_cnt, fill, 8'd0, 32'd0, 64'd0,
                       sfrp_pkg::ROW_W'(0)};
        end
        sfrp_pkg::S_OUT: begin
          if (out_acc) begin
            m_tvalid <= 1'b0;
            row      <= row + sfrp_pkg::ROW_W'(1);
            ch       <= '0;
            samples  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/sfrp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_store
// Frame byte ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfrp_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [sfrp_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic [sfrp_pkg::ADDR_W-1:0]  rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [sfrp_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/sfrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_checker
// Port-level checks for the frame resync parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfrp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [sfrp_pkg::ODATA_W-1:0] m_tdata,
  input logic [0:0]   m_tuser,
  input logic         m_tlast
);

  // one word in flight: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready while result pending");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast) else $error("status word without last");

  a_row_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[114:108] == 7'd0))
    else $error("row word with pending bytes");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[114:108] <= 7'(sfrp_pkg::FRAME_BYTES)))
    else $error("pending count out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind sensor_frame_resync_parser_unit sfrp_checker u_sfrp_checker (.*);
